// ===== design/rau_pkg.sv =====
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package rau_pkg;
    localparam int W = 16;
    localparam int OP_BITS = 3;
    // op a_num a_den b_num b_den exponent, padded to whole bytes
    localparam int S_TDATA_BITS = ((OP_BITS + 5 * W + 7) / 8) * 8;
    // res_num res_den undefined, padded to whole bytes
    localparam int M_TDATA_BITS = ((2 * W + 1 + 7) / 8) * 8;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
        OP_DIV = 3'd3, OP_ABS = 3'd4, OP_POW = 3'd5
    } op_e_t;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_MUL1, CMD_MUL2, CMD_ADDN, CMD_MAG,
        CMD_GCD_INIT, CMD_GCD_STEP, CMD_DIV_START, CMD_DIV_STEP, CMD_DIV_DONE,
        CMD_NEG_B, CMD_POW_INIT, CMD_POW_STEP, CMD_POW_FIX, CMD_BAD
    } cmd_t;

    typedef struct packed {
        logic gcd_more;    // second value still positive
        logic gcd_zero;    // gcd result is zero
        logic div_last;    // last quotient bit
        logic pow_more;    // exponent bits remain
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_ADDN, ST_GCDI, ST_GCD, ST_GDIV, ST_DIVQ,
        ST_DIVD, ST_POWI, ST_POW, ST_POWF, ST_NEGB, ST_OUT
    } state_t;
endpackage

// ===== design/rau_ctrl.sv =====
// rau_ctrl: sequencer for the rational arithmetic unit
// depends on rau_pkg
`timescale 1ns / 1ps
module rau_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rau_pkg::OP_BITS-1:0] op,
    input  rau_pkg::stat_t              stat,
    input  logic                        out_free,
    output rau_pkg::cmd_t               cmd,
    output logic                        busy,
    output logic                        done
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    logic [OP_BITS-1:0] op_reg, op_next;
    logic phase_reg, phase_next;  // subtract: first pass reduces -b
    logic div_pass_reg, div_pass_next; // 0 numerator, 1 denominator

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= '0;
            phase_reg <= 1'b0;
            div_pass_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            phase_reg <= phase_next;
            div_pass_reg <= div_pass_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        phase_next = phase_reg;
        div_pass_next = div_pass_reg;
        cmd = CMD_NONE;
        done = 1'b0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd = CMD_LOAD;
                    op_next = op;
                    phase_next = 1'b0;
                    case (op)
                        OP_ADD: state_next = ST_MUL1;
                        OP_SUB: state_next = ST_NEGB;
                        OP_MUL, OP_DIV: state_next = ST_MUL2;
                        OP_ABS: state_next = ST_ADDN;
                        OP_POW: state_next = ST_POWI;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_NEGB: begin
                cmd = CMD_NEG_B;
                phase_next = 1'b1;
                state_next = ST_GCDI;
            end
            ST_MUL1: begin
                cmd = CMD_MUL1;
                state_next = ST_ADDN;
            end
            ST_MUL2: begin
                cmd = CMD_MUL2;
                state_next = ST_GCDI;
            end
            ST_ADDN: begin
                cmd = (op_reg == OP_ABS) ? CMD_MAG : CMD_ADDN;
                state_next = ST_GCDI;
            end
            ST_GCDI: begin
                cmd = CMD_GCD_INIT;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (stat.gcd_more) begin
                    cmd = CMD_DIV_START;
                    div_pass_next = 1'b0;
                    state_next = ST_DIVQ;
                end else if (stat.gcd_zero) begin
                    cmd = CMD_BAD;
                    state_next = ST_OUT;
                end else begin
                    cmd = CMD_DIV_START;
                    div_pass_next = 1'b0;
                    state_next = ST_GDIV;
                end
            end
            ST_DIVQ: begin
                cmd = CMD_DIV_STEP;
                if (stat.div_last) state_next = ST_DIVD;
            end
            ST_DIVD: begin
                // remainder step of euclid
                cmd = CMD_GCD_STEP;
                state_next = ST_GCD;
            end
            ST_GDIV: begin
                cmd = CMD_DIV_STEP;
                if (stat.div_last) begin
                    state_next = ST_POWF;
                end
            end
            ST_POWF: begin
                if (op_reg == OP_POW) begin
                    cmd = CMD_POW_FIX;
                    state_next = ST_OUT;
                end else begin
                    cmd = CMD_DIV_DONE;
                    if (!div_pass_reg) begin
                        div_pass_next = 1'b1;
                        state_next = ST_GDIV;
                    end else if (op_reg == OP_SUB && phase_reg) begin
                        phase_next = 1'b0;
                        state_next = ST_MUL1;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_POWI: begin
                cmd = CMD_POW_INIT;
                state_next = ST_POW;
            end
            ST_POW: begin
                if (stat.pow_more) cmd = CMD_POW_STEP;
                else begin
                    cmd = CMD_NONE;
                    state_next = ST_POWF;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> state_reg == ST_OUT)
        else $error("done outside output state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && start) |=> busy)
        else $error("start not taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> state_reg == ST_IDLE)
        else $error("no return to idle");
endmodule

// ===== design/rau_dp.sv =====
// rau_dp: datapath with multipliers, a restoring bit-serial divider and the
// gcd and power registers; depends on rau_pkg
`timescale 1ns / 1ps
module rau_dp (
    input  logic                          aclk,
    input  rau_pkg::cmd_t                 cmd,
    input  logic [rau_pkg::OP_BITS-1:0]   op,
    input  logic signed [rau_pkg::W-1:0]  a_num,
    input  logic signed [rau_pkg::W-1:0]  a_den,
    input  logic signed [rau_pkg::W-1:0]  b_num,
    input  logic signed [rau_pkg::W-1:0]  b_den,
    input  logic signed [rau_pkg::W-1:0]  exponent,
    output rau_pkg::stat_t                stat,
    output logic signed [rau_pkg::W-1:0]  res_num,
    output logic signed [rau_pkg::W-1:0]  res_den,
    output logic                          undefined
);
    import rau_pkg::*;

    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W-1:0] ex_reg;            // exponent held from the load
    logic signed [W-1:0] rn_reg, rd_reg;    // working rational
    logic signed [W-1:0] t1_reg;            // partial product
    logic signed [W-1:0] p_reg, q_reg;      // euclid pair
    logic [W-1:0] dvd_reg, dvs_reg, quo_reg, rem_reg;
    logic dneg_reg, rneg_reg;
    logic [4:0] cnt_reg;
    logic [W:0] e_reg;                      // exponent magnitude
    logic signed [W-1:0] pn_reg, pd_reg, accn_reg, accd_reg;
    logic undef_reg;
    logic expo_neg_reg;                     // operand inverted for the power
    logic which_reg; // 0 numerator, 1 denominator in normalising divide

    logic signed [W-1:0] mul_a, mul_b, mul_p;
    logic [W:0] trial;
    logic [W-1:0] rem_sh;
    logic signed [W-1:0] q_res, r_res;
    logic signed [W-1:0] base_n, base_d, pow_n, pow_d;

    function automatic logic signed [W-1:0] mag_f(input logic signed [W-1:0] v);
        mag_f = v[W-1] ? -v : v;
    endfunction

    assign mul_p = W'(mul_a * mul_b);
    always_comb begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (cmd)
            CMD_MUL1: begin mul_a = bn_reg; mul_b = ad_reg; end
            CMD_ADDN: begin mul_a = an_reg; mul_b = bd_reg; end
            default: begin mul_a = an_reg; mul_b = bd_reg; end
        endcase
    end

    assign rem_sh = {rem_reg[W-2:0], dvd_reg[W-1]};
    assign trial = {1'b0, rem_sh} - {1'b0, dvs_reg};

    assign stat.gcd_more = (q_reg > 0);
    assign stat.gcd_zero = (p_reg == '0);
    assign stat.div_last = (cnt_reg == 5'd0);
    assign stat.pow_more = (e_reg != '0);

    // signed results of the finished division (truncating)
    assign q_res = dneg_reg ? -quo_reg : quo_reg;
    assign r_res = rneg_reg ? -rem_reg : rem_reg;

    // original power bases; a base of 0 or 1 keeps its value for any exponent
    assign base_n = expo_neg_reg ? ad_reg : an_reg;
    assign base_d = expo_neg_reg ? an_reg : ad_reg;
    assign pow_n = (base_n == '0) ? '0 : (base_n == W'(1)) ? W'(1) : accn_reg;
    assign pow_d = (base_d == '0) ? '0 : (base_d == W'(1)) ? W'(1) : accd_reg;

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_LOAD: begin
                an_reg <= a_num; ad_reg <= a_den;
                bn_reg <= (op == OP_DIV) ? b_den : b_num;
                bd_reg <= (op == OP_DIV) ? b_num : b_den;
                ex_reg <= exponent;
                undef_reg <= ~(op <= OP_POW);
                rn_reg <= '0; rd_reg <= '0;
                which_reg <= 1'b0;
                if (op == OP_SUB) begin
                    rn_reg <= -b_num; rd_reg <= b_den;
                end
            end
            CMD_NEG_B: ;
            CMD_MUL1: t1_reg <= mul_p;
            CMD_MUL2: begin
                rn_reg <= W'(an_reg * bn_reg);
                rd_reg <= W'(ad_reg * bd_reg);
            end
            CMD_ADDN: begin
                rn_reg <= mul_p + t1_reg;
                rd_reg <= W'(ad_reg * bd_reg);
            end
            CMD_MAG: begin
                rn_reg <= mag_f(an_reg); rd_reg <= mag_f(ad_reg);
            end
            CMD_GCD_INIT: begin
                if (mag_f(rd_reg) == '0) begin
                    p_reg <= mag_f(rn_reg); q_reg <= '0;
                end else begin
                    p_reg <= mag_f(rd_reg); q_reg <= mag_f(rn_reg);
                end
                which_reg <= 1'b0;
            end
            CMD_DIV_START: begin
                // either p rem q (q>0, p may be negative) or part / g
                if (q_reg > 0) begin
                    dvd_reg <= mag_f(p_reg); dvs_reg <= q_reg;
                    dneg_reg <= 1'b0; rneg_reg <= p_reg[W-1];
                end else begin
                    dvd_reg <= mag_f(rn_reg); dvs_reg <= mag_f(p_reg);
                    dneg_reg <= rn_reg[W-1] ^ p_reg[W-1];
                    rneg_reg <= 1'b0;
                end
                rem_reg <= '0;
                cnt_reg <= 5'(W - 1);
            end
            CMD_DIV_STEP: begin
                if (!trial[W]) begin
                    rem_reg <= trial[W-1:0]; quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh; quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                if (cnt_reg != 5'd0) cnt_reg <= cnt_reg - 5'd1;
            end
            CMD_GCD_STEP: begin
                p_reg <= q_reg; q_reg <= r_res;
            end
            CMD_DIV_DONE: begin
                if (!which_reg) begin
                    rn_reg <= q_res;
                    which_reg <= 1'b1;
                    dvd_reg <= mag_f(rd_reg); dvs_reg <= mag_f(p_reg);
                    dneg_reg <= rd_reg[W-1] ^ p_reg[W-1];
                    rem_reg <= '0;
                    cnt_reg <= 5'(W - 1);
                end else begin
                    if (q_res[W-1]) begin
                        rn_reg <= -rn_reg; rd_reg <= -q_res;
                    end else rd_reg <= q_res;
                    // next pass of a subtract: the reduced -b becomes b
                    bn_reg <= q_res[W-1] ? -rn_reg : rn_reg;
                    bd_reg <= q_res[W-1] ? -q_res : q_res;
                end
            end
            CMD_BAD: begin
                rn_reg <= '0; rd_reg <= '0; undef_reg <= 1'b1;
                bn_reg <= '0; bd_reg <= '0;
            end
            CMD_POW_INIT: begin
                pn_reg <= ex_reg[W-1] ? ad_reg : an_reg;
                pd_reg <= ex_reg[W-1] ? an_reg : ad_reg;
                e_reg <= ex_reg[W-1] ? -{ex_reg[W-1], ex_reg} : {1'b0, ex_reg};
                expo_neg_reg <= ex_reg[W-1];
                accn_reg <= W'(1); accd_reg <= W'(1);
            end
            CMD_POW_STEP: begin
                if (e_reg[0]) begin
                    accn_reg <= W'(accn_reg * pn_reg);
                    accd_reg <= W'(accd_reg * pd_reg);
                end
                pn_reg <= W'(pn_reg * pn_reg);
                pd_reg <= W'(pd_reg * pd_reg);
                e_reg <= e_reg >> 1;
            end
            CMD_POW_FIX: begin
                rn_reg <= pow_d[W-1] ? -pow_n : pow_n;
                rd_reg <= pow_d[W-1] ? -pow_d : pow_d;
            end
            default: ;
        endcase
    end

    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign undefined = undef_reg;
endmodule

// ===== design/rational_arithmetic_unit.sv =====
// rational_arithmetic_unit: top level, stream ports and output register
// depends on rau_pkg, rau_ctrl, rau_dp
`timescale 1ns / 1ps
// usage:
//   s_ channel: one transfer carries op, two 16-bit rationals and an exponent
//   m_ channel: one transfer per input with the reduced result and undefined flag
//   one item at a time; s_tready is high while the sequencer is idle
//   path from input transfer to m_tvalid: set-up (cross products for add,
//   products for multiply and divide, magnitudes for absolute value), euclid
//   steps and the two normalising divides on the bit-serial divider, then the
//   output register; subtract reduces -b first, then runs the add set-up and a
//   second reduction; unused opcodes go straight to the output state
//   power squares the base for each exponent magnitude bit, then fixes the sign
//   the bit-serial divider is shared by gcd and reduction
//   a new item is taken the cycle after the previous result has moved into the
//   output register, so a stalled receiver holds one result there and one
//   finished item in the sequencer, with s_tready low
//   reset (aresetn low, synchronous) empties the output register and returns
//   the sequencer to idle
module rational_arithmetic_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0] a_num a_den b_num b_den exponent
    input  logic [rau_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // res_num[15:0] res_den[31:16] undefined[32]
    output logic [rau_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import rau_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  busy, done, start, out_free;
    logic signed [W-1:0] rn, rd;
    logic undef;
    logic m_tvalid_reg;
    logic [2*W:0] m_data_reg;

    assign start = s_tvalid && s_tready;
    assign s_tready = !busy;
    assign out_free = !m_tvalid_reg || m_tready;

    rau_ctrl u_ctrl (
        .aclk, .aresetn, .start, .op(s_tdata[OP_BITS-1:0]), .stat, .out_free,
        .cmd, .busy, .done
    );

    rau_dp u_dp (
        .aclk, .cmd, .op(s_tdata[OP_BITS-1:0]),
        .a_num(s_tdata[OP_BITS +: W]), .a_den(s_tdata[OP_BITS + W +: W]),
        .b_num(s_tdata[OP_BITS + 2 * W +: W]), .b_den(s_tdata[OP_BITS + 3 * W +: W]),
        .exponent(s_tdata[OP_BITS + 4 * W +: W]), .stat,
        .res_num(rn), .res_den(rd), .undefined(undef)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (done) m_tvalid_reg <= 1'b1;
        else if (m_tready) m_tvalid_reg <= 1'b0;
    end
    always_ff @(posedge aclk) if (done) m_data_reg <= {undef, rd, rn};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = M_TDATA_BITS'(m_data_reg);

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy)
        else $error("transfer while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> out_free)
        else $error("output overwritten");
endmodule
